// ===== hw/rtl/cgp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CGP netlist evaluator package
// Sizes, mode and function codes, control/status bundles and the node ALU.
// ----------------------------------------------------------------------------
package cgp_pkg;

  localparam int NUM_PRIMARY = 9;
  localparam int NUM_NODES   = 32;
  localparam int NUM_TAPS    = 1;
  localparam int STORE_SIZE  = NUM_PRIMARY + NUM_NODES;

  localparam int SLOT_W = 5;
  localparam int SRC_W  = 6;
  localparam int FUNC_W = 4;
  localparam int BYTE_W = 8;
  localparam int OIDX_W = 3;

  localparam int NODE_IW  = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int TAP_IW   = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
  localparam int STORE_AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int ADDR_W   = (STORE_AW > SRC_W) ? STORE_AW : SRC_W;

  // input item kinds (tuser)
  localparam logic [1:0] MODE_NODE = 2'd0;
  localparam logic [1:0] MODE_TAP  = 2'd1;
  localparam logic [1:0] MODE_PRIM = 2'd2;
  localparam logic [1:0] MODE_EVAL = 2'd3;

  // node functions
  localparam logic [3:0] FN_C255   = 4'd0;
  localparam logic [3:0] FN_ID     = 4'd1;
  localparam logic [3:0] FN_INV    = 4'd2;
  localparam logic [3:0] FN_OR     = 4'd3;
  localparam logic [3:0] FN_NAOB   = 4'd4;
  localparam logic [3:0] FN_AND    = 4'd5;
  localparam logic [3:0] FN_NAND   = 4'd6;
  localparam logic [3:0] FN_XOR    = 4'd7;
  localparam logic [3:0] FN_SHR1   = 4'd8;
  localparam logic [3:0] FN_SHR2   = 4'd9;
  localparam logic [3:0] FN_SWAP   = 4'd10;
  localparam logic [3:0] FN_ADD    = 4'd11;
  localparam logic [3:0] FN_ADDSAT = 4'd12;
  localparam logic [3:0] FN_AVG    = 4'd13;
  localparam logic [3:0] FN_MAX    = 4'd14;
  localparam logic [3:0] FN_MIN    = 4'd15;

  typedef struct packed {
    logic [SRC_W-1:0]  src_a;
    logic [SRC_W-1:0]  src_b;
    logic [FUNC_W-1:0] func;
  } cgp_node_t;

  typedef struct packed {
    logic               load_en;    // load item accepted this cycle
    logic               rd_en;      // issue operand reads
    logic               rd_sel_tap; // port A address from tap table
    logic [NODE_IW-1:0] node_idx;
    logic [TAP_IW-1:0]  tap_idx;
    logic               ex_en;      // node result written back
    logic [NODE_IW-1:0] ex_idx;
    logic               out_load;
    logic [OIDX_W-1:0]  out_index;
    logic               out_last;
  } cgp_cmd_t;

  typedef struct packed {
    logic out_free; // output register empty or draining this cycle
  } cgp_stat_t;

  function automatic logic [BYTE_W-1:0] apply_func(input logic [FUNC_W-1:0] f,
                                                   input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0]   s;
    logic [BYTE_W-1:0] r;
    s = {1'b0, a} + {1'b0, b};
    case (f)
      FN_C255:   r = 8'hFF;
      FN_ID:     r = a;
      FN_INV:    r = ~a;
      FN_OR:     r = a | b;
      FN_NAOB:   r = ~a | b;
      FN_AND:    r = a & b;
      FN_NAND:   r = ~(a & b);
      FN_XOR:    r = a ^ b;
      FN_SHR1:   r = a >> 1;
      FN_SHR2:   r = a >> 2;
      FN_SWAP:   r = {a[3:0], b[3:0]};
      FN_ADD:    r = s[BYTE_W-1:0];
      FN_ADDSAT: r = s[BYTE_W] ? 8'hFF : s[BYTE_W-1:0];
      FN_AVG:    r = s[BYTE_W:1];
      FN_MAX:    r = (a > b) ? a : b;
      FN_MIN:    r = (a < b) ? a : b;
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cgp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CGP datapath
// Node and tap tables, value store with registered reads and write-back
// forwarding, node ALU and the output register.
// ----------------------------------------------------------------------------
module cgp_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cgp_pkg::cgp_cmd_t     cmd_i,
  output cgp_pkg::cgp_stat_t         stat_o,
  input  wire logic [1:0]            in_mode_i,
  input  wire logic [31:0]           in_data_i,
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  output logic [15:0]                m_tdata_o,
  output logic                       m_tlast_o
);
  import cgp_pkg::*;

  logic [SLOT_W-1:0] in_slot;
  logic [SRC_W-1:0]  in_src_a;
  logic [SRC_W-1:0]  in_src_b;
  logic [FUNC_W-1:0] in_func;
  logic [BYTE_W-1:0] in_value;

  assign in_slot  = in_data_i[4:0];
  assign in_src_a = in_data_i[10:5];
  assign in_src_b = in_data_i[16:11];
  assign in_func  = in_data_i[20:17];
  assign in_value = in_data_i[28:21];

  cgp_node_t        node_tbl [NUM_NODES];
  logic [SRC_W-1:0] tap_tbl  [NUM_TAPS];

  logic node_we, tap_we, prim_we;
  assign node_we = cmd_i.load_en && (in_mode_i == MODE_NODE) &&
                   (32'(in_slot) < 32'(NUM_NODES));
  assign tap_we  = cmd_i.load_en && (in_mode_i == MODE_TAP) &&
                   (32'(in_slot) < 32'(NUM_TAPS));
  assign prim_we = cmd_i.load_en && (in_mode_i == MODE_PRIM) &&
                   (32'(in_slot) < 32'(NUM_PRIMARY));

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_tbl[NODE_IW'(in_slot)] <= '{src_a: in_src_a, src_b: in_src_b, func: in_func};
    end
    if (tap_we) begin
      tap_tbl[TAP_IW'(in_slot)] <= in_src_a;
    end
  end

  // read side
  cgp_node_t         rd_node;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  assign rd_node   = node_tbl[cmd_i.node_idx];
  assign rd_addr_a = cmd_i.rd_sel_tap ? ADDR_W'(tap_tbl[cmd_i.tap_idx]) :
                                        ADDR_W'(rd_node.src_a);
  assign rd_addr_b = ADDR_W'(rd_node.src_b);

  // write side: one port, primary loads in idle, node results in evaluation
  logic [BYTE_W-1:0]   ex_result;
  logic                st_we;
  logic [STORE_AW-1:0] st_wa;
  logic [BYTE_W-1:0]   st_wd;
  assign st_we = prim_we || cmd_i.ex_en;
  assign st_wa = cmd_i.ex_en ? (STORE_AW'(NUM_PRIMARY) + STORE_AW'(cmd_i.ex_idx)) :
                               STORE_AW'(in_slot);
  assign st_wd = cmd_i.ex_en ? ex_result : in_value;

  logic [BYTE_W-1:0]     store_mem [STORE_SIZE];
  logic [STORE_SIZE-1:0] store_vld_q;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_wa] <= st_wd;
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_vld_q <= '0;
    end else if (st_we) begin
      store_vld_q[st_wa] <= 1'b1;
    end
  end

  logic [BYTE_W-1:0] mem_a_q, mem_b_q, fwd_data_q;
  logic              vld_a_q, vld_b_q, inr_a_q, inr_b_q, fwd_a_q, fwd_b_q;
  logic [FUNC_W-1:0] func_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      mem_a_q    <= store_mem[rd_addr_a[STORE_AW-1:0]];
      mem_b_q    <= store_mem[rd_addr_b[STORE_AW-1:0]];
      vld_a_q    <= store_vld_q[rd_addr_a[STORE_AW-1:0]];
      vld_b_q    <= store_vld_q[rd_addr_b[STORE_AW-1:0]];
      inr_a_q    <= 32'(rd_addr_a) < 32'(STORE_SIZE);
      inr_b_q    <= 32'(rd_addr_b) < 32'(STORE_SIZE);
      // previous node written back in the same cycle as this read
      fwd_a_q    <= st_we && (rd_addr_a == ADDR_W'(st_wa));
      fwd_b_q    <= st_we && (rd_addr_b == ADDR_W'(st_wa));
      fwd_data_q <= st_wd;
      func_q     <= rd_node.func;
    end
  end

  logic [BYTE_W-1:0] op_a, op_b;
  assign op_a = !inr_a_q ? '0 : fwd_a_q ? fwd_data_q : vld_a_q ? mem_a_q : '0;
  assign op_b = !inr_b_q ? '0 : fwd_b_q ? fwd_data_q : vld_b_q ? mem_b_q : '0;

  assign ex_result = apply_func(func_q, op_a, op_b);

  // output register
  logic              out_vld_q;
  logic [OIDX_W-1:0] out_idx_q;
  logic [BYTE_W-1:0] out_val_q;
  logic              out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q  <= cmd_i.out_index;
      out_val_q  <= op_a;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign stat_o.out_free = !out_vld_q || m_tready_i;
  assign m_tvalid_o      = out_vld_q;
  assign m_tdata_o       = {5'b0, out_val_q, out_idx_q};
  assign m_tlast_o       = out_last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/cgp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CGP controller
// Accepts items, sequences the node pass with overlapped read and write-back,
// then reads the taps one by one into the output register.
// ----------------------------------------------------------------------------
module cgp_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid_i,
  output logic                     s_tready_o,
  input  wire logic [1:0]          in_mode_i,
  input  wire cgp_pkg::cgp_stat_t  stat_i,
  output cgp_pkg::cgp_cmd_t        cmd_o
);
  import cgp_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_NODE   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_TAP_RD = 3'd3;
  localparam logic [2:0] ST_TAP_LD = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [NODE_IW-1:0] node_cnt_q, node_cnt_d;
  logic [NODE_IW-1:0] ex_idx_q, ex_idx_d;
  logic               ex_vld_q, ex_vld_d;
  logic [TAP_IW-1:0]  tap_cnt_q, tap_cnt_d;
  logic               accept, tap_last;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign tap_last   = (tap_cnt_q == TAP_IW'(NUM_TAPS - 1));

  always_comb begin
    state_d    = state_q;
    node_cnt_d = node_cnt_q;
    ex_idx_d   = ex_idx_q;
    ex_vld_d   = ex_vld_q;
    tap_cnt_d  = tap_cnt_q;

    cmd_o            = '0;
    cmd_o.load_en    = accept && (in_mode_i != MODE_EVAL);
    cmd_o.node_idx   = node_cnt_q;
    cmd_o.ex_idx     = ex_idx_q;
    cmd_o.tap_idx    = tap_cnt_q;
    cmd_o.out_index  = OIDX_W'(tap_cnt_q);
    cmd_o.out_last   = tap_last;

    case (state_q)
      ST_IDLE: begin
        if (accept && (in_mode_i == MODE_EVAL)) begin
          state_d    = ST_NODE;
          node_cnt_d = '0;
          ex_vld_d   = 1'b0;
        end
      end
      ST_NODE: begin
        // read node n while node n-1 writes back
        cmd_o.rd_en = 1'b1;
        cmd_o.ex_en = ex_vld_q;
        ex_vld_d    = 1'b1;
        ex_idx_d    = node_cnt_q;
        if (node_cnt_q == NODE_IW'(NUM_NODES - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          node_cnt_d = node_cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        cmd_o.ex_en = 1'b1;
        ex_vld_d    = 1'b0;
        tap_cnt_d   = '0;
        state_d     = ST_TAP_RD;
      end
      ST_TAP_RD: begin
        if (stat_i.out_free) begin
          cmd_o.rd_en      = 1'b1;
          cmd_o.rd_sel_tap = 1'b1;
          state_d          = ST_TAP_LD;
        end
      end
      ST_TAP_LD: begin
        cmd_o.out_load = 1'b1;
        if (tap_last) begin
          state_d = ST_IDLE;
        end else begin
          tap_cnt_d = tap_cnt_q + 1'b1;
          state_d   = ST_TAP_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      node_cnt_q <= '0;
      ex_idx_q   <= '0;
      ex_vld_q   <= 1'b0;
      tap_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      node_cnt_q <= node_cnt_d;
      ex_idx_q   <= ex_idx_d;
      ex_vld_q   <= ex_vld_d;
      tap_cnt_q  <= tap_cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cgp_netlist_evaluator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CGP netlist evaluator
// Loads a feed-forward netlist of byte nodes and evaluates it on command.
// ----------------------------------------------------------------------------
// Load transactions (node, tap, primary input) give no result. An evaluate
// transaction runs the node pass: one node per cycle through the value
// store's two read ports, with the previous node's result forwarded, and a
// drain state to write back the last node. After that each tap is a store
// read, then an output register load. A tap waits while the output is
// stalled.
// Sources at a node's own or a later slot see the previous evaluation; store
// entries read zero after reset without a clearing pass. New transactions
// are taken only between evaluations, also while a result waits on the
// output.
module cgp_netlist_evaluator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // slot[4:0], src_a[10:5], src_b[16:11], func[20:17], value[28:21], zero pad
  input  wire logic [31:0] s_axis_tdata_i,
  // mode[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // out_index[2:0], out_value[10:3], zero pad
  output logic [15:0]      m_axis_tdata_o,
  // last
  output logic             m_axis_tlast_o
);
  import cgp_pkg::*;

  cgp_cmd_t  cmd;
  cgp_stat_t stat;

  cgp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .in_mode_i  (s_axis_tuser_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cgp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_mode_i  (s_axis_tuser_i),
    .in_data_i  (s_axis_tdata_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !m_axis_tvalid_o)
    else $error("output register overwritten");

  // node write-back never competes with a load on the store write port
  a_wport_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !cmd.ex_en)
    else $error("write-back while accepting transactions");

  // a tap read is always followed by the output load
  a_tap_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rd_en && cmd.rd_sel_tap) |=> cmd.out_load)
    else $error("tap read without output load");

  // tap reads never overlap the node pass
  a_tap_vs_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_sel_tap |-> !cmd.ex_en)
    else $error("tap read during node write-back");

endmodule
`default_nettype wire
